### design/bls_pkg.sv
`timescale 1ns / 1ps
// Shared widths, request codes and the line state record for the line stepper.
// Depends on nothing; every other design file refers to it by scoped names.
package bls_pkg;

    localparam int COORD_BITS = 12;
    localparam int STEP_BITS  = 5;
    localparam int MSTEP_BITS = STEP_BITS + 1;
    localparam int DEC_BITS   = COORD_BITS + 3;
    localparam int SUM_BITS   = ((COORD_BITS > STEP_BITS) ? COORD_BITS : STEP_BITS) + 1;

    typedef logic [COORD_BITS-1:0]        coord_t;
    typedef logic [STEP_BITS-1:0]         step_t;
    typedef logic signed [MSTEP_BITS-1:0] mstep_t;
    typedef logic signed [DEC_BITS-1:0]   dec_t;
    typedef logic [SUM_BITS-1:0]          sum_t;

    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    typedef struct packed {
        coord_t cur_x;
        coord_t cur_y;
        coord_t major_end;
        dec_t   decision;
        dec_t   incr_straight;
        dec_t   incr_diagonal;
        mstep_t minor_step;
        step_t  major_step;
        logic   x_is_major;
        logic   busy;
    } line_state_t;

endpackage

### design/bls_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and emitted pixels.
// Depends on bls_pkg for the coordinate and step types.
interface bls_req_if;
    logic            valid;
    logic            ready;
    logic            req_type;
    bls_pkg::coord_t start_x;
    bls_pkg::coord_t start_y;
    bls_pkg::coord_t end_x;
    bls_pkg::coord_t end_y;
    bls_pkg::step_t  step_size;

    modport source (output valid, req_type, start_x, start_y, end_x, end_y, step_size,
                    input ready);
    modport sink (input valid, req_type, start_x, start_y, end_x, end_y, step_size,
                  output ready);
endinterface

interface bls_pix_if;
    logic            valid;
    logic            ready;
    bls_pkg::coord_t pixel_x;
    bls_pkg::coord_t pixel_y;
    logic            last_pixel;

    modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
    modport sink (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

### design/bls_line_setup.sv
`timescale 1ns / 1ps
// Start-of-line setup: picks the major axis, orders the endpoints and derives
// the initial decision value and increments. Depends on bls_pkg.
module bls_line_setup (
    input  bls_pkg::coord_t      start_x,
    input  bls_pkg::coord_t      start_y,
    input  bls_pkg::coord_t      end_x,
    input  bls_pkg::coord_t      end_y,
    input  bls_pkg::step_t       step_size,
    output bls_pkg::line_state_t setup
);

    localparam int PAD_BITS = bls_pkg::DEC_BITS - bls_pkg::COORD_BITS;

    logic signed [bls_pkg::COORD_BITS:0] dx;
    logic signed [bls_pkg::COORD_BITS:0] dy;
    logic signed [bls_pkg::COORD_BITS:0] adx;
    logic signed [bls_pkg::COORD_BITS:0] ady;
    logic            x_major;
    bls_pkg::coord_t p0;
    bls_pkg::coord_t q0;
    bls_pkg::coord_t p1;
    bls_pkg::coord_t q1;
    bls_pkg::coord_t a0;
    bls_pkg::coord_t b0;
    bls_pkg::coord_t a1;
    bls_pkg::coord_t b1;
    bls_pkg::dec_t   d_major;
    bls_pkg::dec_t   d_minor_raw;
    bls_pkg::dec_t   d_minor;
    bls_pkg::mstep_t step_s;

    always_comb
    begin
        dx  = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
        dy  = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        x_major = ady < adx;

        p0 = x_major ? start_x : start_y;
        q0 = x_major ? start_y : start_x;
        p1 = x_major ? end_x : end_y;
        q1 = x_major ? end_y : end_x;

        if (p0 > p1)
        begin
            a0 = p1;
            b0 = q1;
            a1 = p0;
            b1 = q0;
        end
        else
        begin
            a0 = p0;
            b0 = q0;
            a1 = p1;
            b1 = q1;
        end

        d_major     = $signed({{PAD_BITS{1'b0}}, a1}) - $signed({{PAD_BITS{1'b0}}, a0});
        d_minor_raw = $signed({{PAD_BITS{1'b0}}, b1}) - $signed({{PAD_BITS{1'b0}}, b0});
        d_minor     = (d_minor_raw < 0) ? -d_minor_raw : d_minor_raw;
        step_s      = $signed({1'b0, step_size});

        setup.minor_step    = (d_minor_raw < 0) ? -step_s : step_s;
        setup.major_step    = step_size;
        setup.incr_straight = d_minor <<< 1;
        setup.incr_diagonal = (d_minor - d_major) <<< 1;
        setup.decision      = (d_minor <<< 1) - d_major;
        setup.major_end     = a1;
        setup.cur_x         = x_major ? a0 : b0;
        setup.cur_y         = x_major ? b0 : a0;
        setup.x_is_major    = x_major;
        setup.busy          = a0 < a1;
    end

endmodule

### design/bresenham_line_stepper.sv
`timescale 1ns / 1ps
// Bresenham line stepper top level: line state registers and the pixel output register.
// Depends on bls_pkg, bls_if and bls_line_setup.
// A pixel appears at the output in the cycle after its advance item is accepted.
// Throughput: one item per cycle while the pixel output is not stalled, set by the adds and compare on the line state.
// The output register accepts a new item while the previous pixel is taken in the same cycle.
// Reset (rst_n low, asynchronous) clears the line state to idle and empties the output.
module bresenham_line_stepper (
    input logic       clk,
    input logic       rst_n,
    bls_req_if.sink   req,
    bls_pix_if.source pix
);

    localparam int MAJ_PAD  = bls_pkg::SUM_BITS - bls_pkg::COORD_BITS;
    localparam int STEP_PAD = bls_pkg::SUM_BITS - bls_pkg::STEP_BITS;

    bls_pkg::line_state_t state_reg;
    bls_pkg::line_state_t state_next;
    bls_pkg::line_state_t setup;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    bls_pkg::coord_t      out_x_reg;
    bls_pkg::coord_t      out_y_reg;
    logic                 out_last_reg;

    logic            accept;
    logic            emit;
    bls_pkg::coord_t major;
    bls_pkg::coord_t minor;
    bls_pkg::coord_t minor_new;
    bls_pkg::sum_t   next_major;
    logic            last;
    bls_pkg::coord_t new_x;
    bls_pkg::coord_t new_y;

    bls_line_setup u_setup (
        .start_x   (req.start_x),
        .start_y   (req.start_y),
        .end_x     (req.end_x),
        .end_y     (req.end_y),
        .step_size (req.step_size),
        .setup     (setup)
    );

    assign req.ready = !out_valid_reg || pix.ready;
    assign accept    = req.valid && req.ready;
    assign emit      = accept && (req.req_type == bls_pkg::REQ_ADVANCE) && state_reg.busy;

    always_comb
    begin
        major      = state_reg.x_is_major ? state_reg.cur_x : state_reg.cur_y;
        minor      = state_reg.x_is_major ? state_reg.cur_y : state_reg.cur_x;
        next_major = {{MAJ_PAD{1'b0}}, major} + {{STEP_PAD{1'b0}}, state_reg.major_step};
        last       = next_major >= {{MAJ_PAD{1'b0}}, state_reg.major_end};
        minor_new  = minor;

        state_next = state_reg;
        if (state_reg.decision > 0)
        begin
            state_next.decision = state_reg.decision + state_reg.incr_diagonal;
            minor_new = minor + bls_pkg::coord_t'(state_reg.minor_step);
        end
        else
        begin
            state_next.decision = state_reg.decision + state_reg.incr_straight;
        end

        new_x = state_reg.x_is_major ? next_major[bls_pkg::COORD_BITS-1:0] : minor_new;
        new_y = state_reg.x_is_major ? minor_new : next_major[bls_pkg::COORD_BITS-1:0];
        state_next.cur_x = new_x;
        state_next.cur_y = new_y;
        state_next.busy  = !last;

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pix.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept && (req.req_type == bls_pkg::REQ_START))
            begin
                state_reg <= setup;
            end
            else if (emit)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_x_reg    <= new_x;
            out_y_reg    <= new_y;
            out_last_reg <= last;
        end
    end

    assign pix.valid      = out_valid_reg;
    assign pix.pixel_x    = out_x_reg;
    assign pix.pixel_y    = out_y_reg;
    assign pix.last_pixel = out_last_reg;

endmodule
